>>> sv/first_fit_heap_allocator_defines.svh
// Assertion macros used by the heap allocator sequencer RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Condition that holds at every clock edge out of reset
`define FFHA_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that holds in the same cycle as the antecedent
`define FFHA_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence that holds in the cycle after the antecedent
`define FFHA_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ffha_pkg.sv
// Types, constants and codes shared by the heap allocator modules.
package ffha_pkg;

  localparam int MAX_SEG = 64;
  localparam int IDX_W   = $clog2(MAX_SEG);
  localparam int CNT_W   = IDX_W + 1;
  localparam int HDR     = 24;
  localparam int ADDR_W  = 48;
  localparam int SIZE_W  = 32;

  localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(MAX_SEG);
  localparam logic [31:0]       HDR32      = 32'(HDR);
  localparam logic [33:0]       HDR34      = 34'(HDR);
  localparam logic [33:0]       MIN_SPLIT  = 34'(HDR + 16);
  localparam logic [47:0]       HDR48      = 48'(HDR);
  localparam logic [31:0]       BYTES_RST  = 32'd1048576;

  // Request kinds
  localparam logic [1:0] K_ALLOC  = 2'd0;
  localparam logic [1:0] K_FREE   = 2'd1;
  localparam logic [1:0] K_RESIZE = 2'd2;
  localparam logic [1:0] K_UNUSED = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NULL    = 2'd1;
  localparam logic [1:0] ST_OOM     = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // Configuration register indexes
  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_BYTES = 1'b1;

  typedef struct packed {
    logic        free;
    logic [31:0] len;
    logic [31:0] off;
  } seg_t;

  localparam int SEG_W = $bits(seg_t);

  typedef struct packed {
    logic [31:0] copy_bytes;
    logic [47:0] copy_from;
    logic [1:0]  status;
    logic [47:0] result_addr;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    seg_t             wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

>>> sv/ffha_seg_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module ffha_seg_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/ffha_ctrl.sv
// Request sequencer: scans, splits, shifts and coalesces the segment table.
`include "first_fit_heap_allocator_defines.svh"

module ffha_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [47:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic [47:0]                   in_addr,
  input  logic [31:0]                   in_size,
  output logic                          res_valid,
  output ffha_pkg::res_t                res,
  input  logic                          res_taken,
  output ffha_pkg::mem_req_t            mem_req,
  input  logic [ffha_pkg::SEG_W-1:0]    mem_rdata
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_INIT   = 5'd1;
  localparam logic [4:0] S_F_RD   = 5'd2;
  localparam logic [4:0] S_F_CHK  = 5'd3;
  localparam logic [4:0] S_A_RD   = 5'd4;
  localparam logic [4:0] S_A_CHK  = 5'd5;
  localparam logic [4:0] S_N_RD   = 5'd6;
  localparam logic [4:0] S_N_CHK  = 5'd7;
  localparam logic [4:0] S_SH_RD  = 5'd8;
  localparam logic [4:0] S_SH_WR  = 5'd9;
  localparam logic [4:0] S_INS    = 5'd10;
  localparam logic [4:0] S_WR_I   = 5'd11;
  localparam logic [4:0] S_RM_RD  = 5'd12;
  localparam logic [4:0] S_RM_WR  = 5'd13;
  localparam logic [4:0] S_CO_RD0 = 5'd14;
  localparam logic [4:0] S_CO_LD  = 5'd15;
  localparam logic [4:0] S_CO_RD  = 5'd16;
  localparam logic [4:0] S_CO_MG  = 5'd17;
  localparam logic [4:0] S_CO_END = 5'd18;
  localparam logic [4:0] S_DONE   = 5'd19;

  logic [4:0]                   st;
  logic [4:0]                   wr_next;
  logic [47:0]                  heap_base;
  logic [31:0]                  heap_bytes;
  logic [1:0]                   kind_r;
  logic [47:0]                  addr_r;
  logic [31:0]                  size_r;
  logic [32:0]                  need_r;
  logic [ffha_pkg::CNT_W-1:0]   cnt;
  logic [ffha_pkg::CNT_W-1:0]   idx;
  logic [ffha_pkg::CNT_W-1:0]   j;
  logic [ffha_pkg::IDX_W-1:0]   hit;
  logic                         moving;
  logic                         e_free;
  logic [31:0]                  e_off;
  logic [31:0]                  e_len;
  logic [31:0]                  n_off;
  logic [31:0]                  n_len;
  logic [31:0]                  old_len;
  ffha_pkg::seg_t               cur;
  ffha_pkg::res_t               res_r;

  ffha_pkg::seg_t               rd;
  logic [32:0]                  need_in;
  logic [47:0]                  rd_payload;
  logic                         rd_fit;
  logic                         rd_split;
  logic [33:0]                  grow_sum;
  logic [33:0]                  grow_left;
  logic [ffha_pkg::CNT_W-1:0]   hit_p1;
  logic [31:0]                  init_len;
  logic                         in_fire;
  logic                         f_release;

  assign rd         = ffha_pkg::seg_t'(mem_rdata);
  assign need_in    = ({1'b0, in_size} + 33'd15) & ~33'd15;
  assign rd_payload = heap_base + {16'b0, rd.off} + ffha_pkg::HDR48;
  assign rd_fit     = rd.free && ({1'b0, rd.len} >= need_r);
  assign rd_split   = ({2'b0, rd.len} >= ({1'b0, need_r} + ffha_pkg::MIN_SPLIT))
                      && (cnt < ffha_pkg::MAX_CNT);
  assign grow_sum   = {2'b0, e_len} + ffha_pkg::HDR34 + {2'b0, rd.len};
  assign grow_left  = grow_sum - {1'b0, need_r};
  assign hit_p1     = {1'b0, hit} + ffha_pkg::CNT_W'(1);
  assign init_len   = (heap_bytes > ffha_pkg::HDR32) ? (heap_bytes - ffha_pkg::HDR32) : 32'd0;
  assign f_release  = moving || (kind_r == ffha_pkg::K_FREE) || (size_r == 32'd0);
  assign in_ready   = (st == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign res_valid  = (st == S_DONE);
  assign res        = res_r;

  // drive the table memory from the current step
  always_comb begin
    mem_req       = '0;
    mem_req.raddr = idx[ffha_pkg::IDX_W-1:0];
    case (st)
      S_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = '0;
        mem_req.wdata = '{free: 1'b1, len: init_len, off: 32'd0};
      end
      S_F_RD, S_A_RD, S_CO_RD: begin
        mem_req.re = 1'b1;
      end
      S_N_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = hit_p1[ffha_pkg::IDX_W-1:0];
      end
      S_SH_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = ffha_pkg::IDX_W'(j - ffha_pkg::CNT_W'(1));
      end
      S_SH_WR, S_RM_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = j[ffha_pkg::IDX_W-1:0];
        mem_req.wdata = rd;
      end
      S_INS: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = hit_p1[ffha_pkg::IDX_W-1:0];
        mem_req.wdata = '{free: 1'b1, len: n_len, off: n_off};
      end
      S_WR_I: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = hit;
        mem_req.wdata = '{free: e_free, len: e_len, off: e_off};
      end
      S_RM_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = ffha_pkg::IDX_W'(j + ffha_pkg::CNT_W'(1));
      end
      S_CO_RD0: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = '0;
      end
      S_CO_MG: begin
        mem_req.we    = !(cur.free && rd.free);
        mem_req.waddr = j[ffha_pkg::IDX_W-1:0];
        mem_req.wdata = cur;
      end
      S_CO_END: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = j[ffha_pkg::IDX_W-1:0];
        mem_req.wdata = cur;
      end
      default: begin
      end
    endcase
  end

  // sequence one request through the table
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_INIT;
      cnt        <= ffha_pkg::CNT_W'(1);
      heap_base  <= '0;
      heap_bytes <= ffha_pkg::BYTES_RST;
      moving     <= 1'b0;
    end else if (cfg_we) begin
      // re-initialise the table after any register write
      if (cfg_addr == ffha_pkg::REG_BASE) begin
        heap_base <= cfg_data;
      end else begin
        heap_bytes <= cfg_data[31:0];
      end
      st <= S_INIT;
    end else begin
      case (st)
        S_INIT: begin
          cnt <= ffha_pkg::CNT_W'(1);
          st  <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire) begin
            kind_r <= in_kind;
            addr_r <= in_addr;
            size_r <= in_size;
            need_r <= need_in;
            moving <= 1'b0;
            idx    <= '0;
            res_r  <= '{copy_bytes: 32'd0, copy_from: 48'd0,
                        status: ffha_pkg::ST_NULL, result_addr: 48'd0};
            if (in_kind == ffha_pkg::K_ALLOC) begin
              st <= (in_size == 32'd0) ? S_DONE : S_A_RD;
            end else if (in_kind == ffha_pkg::K_FREE) begin
              st <= (in_addr == 48'd0) ? S_DONE : S_F_RD;
            end else if (in_kind == ffha_pkg::K_RESIZE) begin
              if (in_addr != 48'd0) begin
                st <= S_F_RD;
              end else begin
                st <= (in_size == 32'd0) ? S_DONE : S_A_RD;
              end
            end else begin
              st <= S_DONE;
            end
          end
        end
        // look for the allocated segment whose payload is addr
        S_F_RD: begin
          if (idx < cnt) begin
            st <= S_F_CHK;
          end else begin
            if (!moving) begin
              res_r.status <= ffha_pkg::ST_UNKNOWN;
            end
            st <= S_DONE;
          end
        end
        S_F_CHK: begin
          if (!rd.free && (rd_payload == addr_r)) begin
            hit    <= idx[ffha_pkg::IDX_W-1:0];
            e_off  <= rd.off;
            e_free <= f_release;
            n_off  <= rd.off + ffha_pkg::HDR32 + need_r[31:0];
            n_len  <= rd.len - need_r[31:0] - ffha_pkg::HDR32;
            if (f_release) begin
              // release the block and merge free runs
              e_len   <= rd.len;
              wr_next <= S_CO_RD0;
              st      <= S_WR_I;
              if (!moving) begin
                res_r.status <= (kind_r == ffha_pkg::K_FREE) ? ffha_pkg::ST_OK
                                                             : ffha_pkg::ST_NULL;
              end
            end else if (need_r <= {1'b0, rd.len}) begin
              // shrink in place
              res_r.status      <= ffha_pkg::ST_OK;
              res_r.result_addr <= addr_r;
              if (rd_split) begin
                e_len   <= need_r[31:0];
                j       <= cnt;
                cnt     <= cnt + ffha_pkg::CNT_W'(1);
                wr_next <= S_DONE;
                st      <= S_SH_RD;
              end else begin
                st <= S_DONE;
              end
            end else if ((idx + ffha_pkg::CNT_W'(1)) < cnt) begin
              e_len <= rd.len;
              st    <= S_N_RD;
            end else begin
              moving  <= 1'b1;
              old_len <= rd.len;
              idx     <= '0;
              st      <= S_A_RD;
            end
          end else begin
            idx <= idx + ffha_pkg::CNT_W'(1);
            st  <= S_F_RD;
          end
        end
        S_N_RD: begin
          st <= S_N_CHK;
        end
        // try to grow into the free successor
        S_N_CHK: begin
          if (rd.free && (grow_sum >= {1'b0, need_r})) begin
            res_r.status      <= ffha_pkg::ST_OK;
            res_r.result_addr <= addr_r;
            if (grow_left >= ffha_pkg::MIN_SPLIT) begin
              n_off   <= e_off + ffha_pkg::HDR32 + need_r[31:0];
              n_len   <= 32'(grow_left - ffha_pkg::HDR34);
              e_len   <= need_r[31:0];
              wr_next <= S_DONE;
              st      <= S_INS;
            end else begin
              e_len   <= grow_sum[31:0];
              wr_next <= S_RM_RD;
              st      <= S_WR_I;
            end
          end else begin
            moving  <= 1'b1;
            old_len <= e_len;
            idx     <= '0;
            st      <= S_A_RD;
          end
        end
        // first-fit scan
        S_A_RD: begin
          if (idx < cnt) begin
            st <= S_A_CHK;
          end else begin
            res_r.status      <= ffha_pkg::ST_OOM;
            res_r.result_addr <= 48'd0;
            st                <= S_DONE;
          end
        end
        S_A_CHK: begin
          if (rd_fit) begin
            hit               <= idx[ffha_pkg::IDX_W-1:0];
            e_off             <= rd.off;
            e_len             <= rd_split ? need_r[31:0] : rd.len;
            e_free            <= 1'b0;
            n_off             <= rd.off + ffha_pkg::HDR32 + need_r[31:0];
            n_len             <= rd.len - need_r[31:0] - ffha_pkg::HDR32;
            res_r.status      <= ffha_pkg::ST_OK;
            res_r.result_addr <= rd_payload;
            if (moving) begin
              res_r.copy_from  <= addr_r;
              res_r.copy_bytes <= old_len;
              wr_next          <= S_F_RD;
            end else begin
              wr_next <= S_DONE;
            end
            if (rd_split) begin
              j     <= cnt;
              cnt   <= cnt + ffha_pkg::CNT_W'(1);
              st    <= S_SH_RD;
            end else begin
              st <= S_WR_I;
            end
          end else begin
            idx <= idx + ffha_pkg::CNT_W'(1);
            st  <= S_A_RD;
          end
        end
        // open a slot after the hit entry, moving each entry up with a read and then a write
        S_SH_RD: begin
          st <= (j > hit_p1) ? S_SH_WR : S_INS;
        end
        S_SH_WR: begin
          j  <= j - ffha_pkg::CNT_W'(1);
          st <= S_SH_RD;
        end
        S_INS: begin
          st <= S_WR_I;
        end
        S_WR_I: begin
          idx <= '0;
          j   <= hit_p1;
          st  <= wr_next;
        end
        // close the gap left by a merged successor
        S_RM_RD: begin
          if (j + ffha_pkg::CNT_W'(1) < cnt) begin
            st <= S_RM_WR;
          end else begin
            cnt <= cnt - ffha_pkg::CNT_W'(1);
            st  <= S_DONE;
          end
        end
        S_RM_WR: begin
          j  <= j + ffha_pkg::CNT_W'(1);
          st <= S_RM_RD;
        end
        // compact the table, merging runs of free segments
        S_CO_RD0: begin
          st <= S_CO_LD;
        end
        S_CO_LD: begin
          cur <= rd;
          idx <= ffha_pkg::CNT_W'(1);
          j   <= '0;
          st  <= S_CO_RD;
        end
        S_CO_RD: begin
          st <= (idx < cnt) ? S_CO_MG : S_CO_END;
        end
        S_CO_MG: begin
          if (cur.free && rd.free) begin
            cur.len <= cur.len + ffha_pkg::HDR32 + rd.len;
          end else begin
            cur <= rd;
            j   <= j + ffha_pkg::CNT_W'(1);
          end
          idx <= idx + ffha_pkg::CNT_W'(1);
          st  <= S_CO_RD;
        end
        S_CO_END: begin
          cnt <= j + ffha_pkg::CNT_W'(1);
          st  <= S_DONE;
        end
        S_DONE: begin
          if (res_taken) begin
            st <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  `FFHA_ALWAYS(a_cnt_range, (cnt != '0) && (cnt <= ffha_pkg::MAX_CNT), "bad segment count")
  `FFHA_ALWAYS(a_no_rw_clash, !(mem_req.we && mem_req.re), "table read and write in one cycle")
  `FFHA_NEXT(a_busy_after_accept, in_fire && !cfg_we, st != S_IDLE, "accepted item left no work")
  `FFHA_NEXT(a_hold_res, (st == S_DONE) && !res_taken && !cfg_we, st == S_DONE, "result dropped")

endmodule

>>> sv/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: table memory, sequencer, output register.
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------
//  s_axis   | in        | kind, addr, size
//  m_axis   | out       | result_addr, status, copy_from, copy_bytes
//  cfg      | in        | heap_base (index 0), heap_bytes (index 1)
//
// Each table pass handles one segment at a time, a memory read and then a check or write,
// with one table access per cycle and registered read data.
// Reset and every register write rebuild the table as a single free segment.
// A result waits in the output register; the next item is taken meanwhile and
// stalls only when its own result finds the register still full.
module first_fit_heap_allocator (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [47:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [87:0]  s_tdata,   // kind[1:0], addr[49:2], size[81:50], zero pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata    // result_addr[47:0], status[49:48], copy_from[97:50],
                                  // copy_bytes[129:98], zero pad
);

  ffha_pkg::res_t                 res;
  ffha_pkg::res_t                 out_r;
  ffha_pkg::mem_req_t             mem_req;
  logic [ffha_pkg::SEG_W-1:0]     mem_rdata;
  logic                           res_valid;
  logic                           res_taken;

  ffha_seg_ram #(
    .WIDTH (ffha_pkg::SEG_W),
    .DEPTH (ffha_pkg::MAX_SEG)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (s_tdata[1:0]),
    .in_addr   (s_tdata[49:2]),
    .in_size   (s_tdata[81:50]),
    .res_valid (res_valid),
    .res       (res),
    .res_taken (res_taken),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  assign res_taken = res_valid && (!m_tvalid || m_tready);

  // hold the result until the sink takes the item
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_taken) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      out_r <= res;
    end
  end

  assign m_tdata = {6'b0, out_r.copy_bytes, out_r.copy_from, out_r.status, out_r.result_addr};

endmodule

>>> tb/tb_top.sv
// Testbench for the first-fit heap allocator: directed and random requests against a predictor.
`timescale 1ns / 1ps

module tb_top;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic         cfg_addr;
  logic [47:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [87:0]  s_tdata;   // kind, addr, size, zero pad
  logic         m_tvalid;
  logic         m_tready;
  logic [135:0] m_tdata;   // result_addr, status, copy_from, copy_bytes, zero pad

  first_fit_heap_allocator u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // Predictor copy of the segment table
  logic [47:0] base_reg;
  logic [31:0] span_reg;
  logic [31:0] t_off [ffha_pkg::MAX_SEG];
  logic [31:0] t_len [ffha_pkg::MAX_SEG];
  logic        t_free [ffha_pkg::MAX_SEG];
  int          t_cnt;

  ffha_pkg::res_t grant_q [$];
  logic [47:0] live_q [$];   // payload addresses currently held
  int          mismatches;
  int          send_idle_pct;
  int          recv_stall_pct;

  function automatic void table_rebuild();
    for (int k = 0; k < ffha_pkg::MAX_SEG; k++) begin
      t_off[k] = '0; t_len[k] = '0; t_free[k] = 1'b0;
    end
    t_len[0] = (span_reg > ffha_pkg::HDR32) ? span_reg - ffha_pkg::HDR32 : 32'd0;
    t_free[0] = 1'b1;
    t_cnt = 1;
  endfunction

  function automatic logic [47:0] payload_at(int k);
    return base_reg + 48'(t_off[k]) + ffha_pkg::HDR48;
  endfunction

  function automatic void seg_insert(int k, logic [63:0] o, logic [63:0] l);
    for (int j = t_cnt; j > k + 1; j--) begin
      t_off[j] = t_off[j-1]; t_len[j] = t_len[j-1]; t_free[j] = t_free[j-1];
    end
    t_off[k+1] = o[31:0]; t_len[k+1] = l[31:0]; t_free[k+1] = 1'b1;
    t_cnt++;
  endfunction

  function automatic void seg_remove(int k);
    for (int j = k; j + 1 < t_cnt; j++) begin
      t_off[j] = t_off[j+1]; t_len[j] = t_len[j+1]; t_free[j] = t_free[j+1];
    end
    t_cnt--;
  endfunction

  function automatic void merge_free();
    int k;
    logic [63:0] s;
    k = 0;
    while (k + 1 < t_cnt) begin
      if (t_free[k] && t_free[k+1]) begin
        s = 64'(t_len[k]) + 64'(ffha_pkg::HDR) + 64'(t_len[k+1]);
        t_len[k] = s[31:0];
        seg_remove(k + 1);
      end else k++;
    end
  endfunction

  function automatic int find_held(logic [47:0] a);
    for (int k = 0; k < t_cnt; k++)
      if (!t_free[k] && payload_at(k) == a) return k;
    return -1;
  endfunction

  function automatic void split_tail(int k, logic [63:0] need);
    logic [63:0] l;
    l = 64'(t_len[k]);
    if (l >= need + 64'(ffha_pkg::HDR) + 64'd16 && t_cnt < ffha_pkg::MAX_SEG) begin
      seg_insert(k, 64'(t_off[k]) + 64'(ffha_pkg::HDR) + need,
                 l - need - 64'(ffha_pkg::HDR));
      t_len[k] = need[31:0];
    end
  endfunction

  function automatic logic [47:0] grant_first_fit(logic [31:0] sz, output logic [1:0] st);
    logic [63:0] need;
    if (sz == 0) begin st = ffha_pkg::ST_NULL; return '0; end
    need = (64'(sz) + 64'd15) & ~64'd15;
    for (int k = 0; k < t_cnt; k++)
      if (t_free[k] && 64'(t_len[k]) >= need) begin
        split_tail(k, need);
        t_free[k] = 1'b0;
        st = ffha_pkg::ST_OK;
        return payload_at(k);
      end
    st = ffha_pkg::ST_OOM;
    return '0;
  endfunction

  // Work out the result of one request and update the table
  function automatic ffha_pkg::res_t heap_predict(logic [1:0] kd, logic [47:0] a,
                                                  logic [31:0] sz);
    ffha_pkg::res_t r;
    int k, old;
    logic [1:0] st;
    logic [63:0] need, l, s, left;
    r = '0;
    r.status = ffha_pkg::ST_NULL;
    if (kd == ffha_pkg::K_ALLOC) begin
      r.result_addr = grant_first_fit(sz, st); r.status = st;
    end else if (kd == ffha_pkg::K_FREE) begin
      if (a != 0) begin
        k = find_held(a);
        if (k < 0) r.status = ffha_pkg::ST_UNKNOWN;
        else begin t_free[k] = 1'b1; merge_free(); r.status = ffha_pkg::ST_OK; end
      end
    end else if (kd == ffha_pkg::K_RESIZE) begin
      k = (a == 0) ? -1 : find_held(a);
      if (a == 0) begin
        r.result_addr = grant_first_fit(sz, st); r.status = st;
      end else if (k < 0) r.status = ffha_pkg::ST_UNKNOWN;
      else if (sz == 0) begin
        t_free[k] = 1'b1; merge_free(); r.status = ffha_pkg::ST_NULL;
      end else begin
        need = (64'(sz) + 64'd15) & ~64'd15;
        l = 64'(t_len[k]);
        s = l + 64'(ffha_pkg::HDR) + ((k + 1 < t_cnt) ? 64'(t_len[k+1]) : 64'd0);
        if (need <= l) begin
          split_tail(k, need);
          r.result_addr = a; r.status = ffha_pkg::ST_OK;
        end else if (k + 1 < t_cnt && t_free[k+1] && s >= need) begin
          left = s - need;
          if (left >= 64'(ffha_pkg::HDR) + 64'd16) begin
            t_off[k+1] = t_off[k] + ffha_pkg::HDR32 + need[31:0];
            t_len[k+1] = 32'(left - 64'(ffha_pkg::HDR));
            t_len[k] = need[31:0];
          end else begin
            t_len[k] = s[31:0];
            seg_remove(k + 1);
          end
          r.result_addr = a; r.status = ffha_pkg::ST_OK;
        end else begin
          r.result_addr = grant_first_fit(sz, st); r.status = st;
          if (st == ffha_pkg::ST_OK) begin
            old = find_held(a);
            if (old >= 0) begin t_free[old] = 1'b1; merge_free(); end
            r.copy_from = a; r.copy_bytes = l[31:0];
          end
        end
      end
    end
    return r;
  endfunction

  // Keep the list of held blocks in step with a request's outcome
  function automatic void track_held(logic [1:0] kd, logic [47:0] a, logic [31:0] sz,
                                     ffha_pkg::res_t r);
    int p;
    p = -1;
    foreach (live_q[j]) if (live_q[j] == a) p = j;
    if (kd == ffha_pkg::K_FREE && r.status == ffha_pkg::ST_OK && p >= 0) live_q.delete(p);
    if (kd == ffha_pkg::K_RESIZE && a != 0 && p >= 0 && (sz == 0 || r.copy_from != 0))
      live_q.delete(p);
    if ((kd == ffha_pkg::K_ALLOC || kd == ffha_pkg::K_RESIZE) &&
        r.status == ffha_pkg::ST_OK && r.result_addr != a)
      live_q.push_back(r.result_addr);
  endfunction

  // Send one item and log its expected result; valid stays high until the next call or a drain
  task automatic send_req(logic [1:0] kd, logic [47:0] a, logic [31:0] sz);
    ffha_pkg::res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, sz, a, kd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = heap_predict(kd, a, sz);
    track_held(kd, a, sz, r);
    grant_q.push_back(r);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [47:0] v);
    drain();
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ffha_pkg::REG_BASE) base_reg = v; else span_reg = v[31:0];
    table_rebuild();
    live_q.delete();
  endtask

  function automatic logic [47:0] pick_held();
    if (live_q.size() == 0) return 48'd0;
    return live_q[$urandom_range(live_q.size() - 1)];
  endfunction

  function automatic logic [31:0] rand_size();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return $urandom_range(16);
      default: return $urandom_range(600);
    endcase
  endfunction

  function automatic logic [47:0] rand_addr();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    ffha_pkg::res_t e, g;
    if (!rst) begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_tvalid && m_tready) begin
        g = m_tdata[129:0];
        if (grant_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", g);
        end else begin
          e = grant_q.pop_front();
          if (g.result_addr != e.result_addr || g.status != e.status ||
              g.copy_from != e.copy_from || g.copy_bytes != e.copy_bytes) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp addr %h st %0d from %h bytes %0d, got %h %0d %h %0d",
                       e.result_addr, e.status, e.copy_from, e.copy_bytes,
                       g.result_addr, g.status, g.copy_from, g.copy_bytes);
          end
        end
      end
    end
  end

  task automatic test_directed();
    logic [47:0] a, b;
    send_req(ffha_pkg::K_ALLOC, 48'd0, 32'd0);
    send_req(ffha_pkg::K_ALLOC, 48'd0, 32'd1);
    a = pick_held();
    send_req(ffha_pkg::K_ALLOC, 48'd0, 32'd100);
    send_req(ffha_pkg::K_ALLOC, 48'd0, 32'hFFFF_FFFF);
    send_req(ffha_pkg::K_ALLOC, 48'd0, 32'hFFFF_FFF1);
    send_req(ffha_pkg::K_FREE, 48'd0, 32'd0);
    send_req(ffha_pkg::K_FREE, 48'hFFFF_FFFF_FFFF, 32'd0);
    send_req(ffha_pkg::K_FREE, a + 48'd16, 32'd0);
    send_req(ffha_pkg::K_RESIZE, a, 32'd8);
    send_req(ffha_pkg::K_RESIZE, a, 32'd200);
    send_req(ffha_pkg::K_RESIZE, a, 32'd5000);
    send_req(ffha_pkg::K_RESIZE, 48'd0, 32'd48);
    send_req(ffha_pkg::K_UNUSED, 48'hAAAA_5555_AAAA, 32'h5555_AAAA);
    b = pick_held();
    send_req(ffha_pkg::K_RESIZE, b, 32'd0);
    send_req(ffha_pkg::K_RESIZE, b, 32'd16);
    send_req(ffha_pkg::K_FREE, a, 32'd0);
    while (live_q.size() != 0) send_req(ffha_pkg::K_FREE, live_q[0], 32'd0);
    send_req(ffha_pkg::K_FREE, a, 32'd0);
  endtask

  task automatic test_tiny_heap();
    write_reg(ffha_pkg::REG_BYTES, 48'd24);
    send_req(ffha_pkg::K_ALLOC, 48'd0, 32'd1);
    send_req(ffha_pkg::K_RESIZE, 48'd0, 32'd16);
    write_reg(ffha_pkg::REG_BYTES, 48'd64);
    send_req(ffha_pkg::K_ALLOC, 48'd0, 32'd16);
    send_req(ffha_pkg::K_ALLOC, 48'd0, 32'd16);
  endtask

  task automatic run_random(int n);
    int op;
    for (int k = 0; k < n; k++) begin
      op = $urandom_range(99);
      if (op < 40) send_req(ffha_pkg::K_ALLOC, 48'd0, rand_size());
      else if (op < 70) send_req(ffha_pkg::K_FREE, pick_held(), 32'd0);
      else if (op < 90) send_req(ffha_pkg::K_RESIZE, pick_held(), rand_size());
      else if (op < 97) send_req(2'($urandom_range(3)), rand_addr(), $urandom);
      else send_req(ffha_pkg::K_RESIZE, pick_held() + 48'd8, rand_size());
    end
  endtask

  // Random traffic over several heap settings and idling phases
  task automatic test_random();
    write_reg(ffha_pkg::REG_BASE, 48'hFFFF_FFFF_FF00);
    write_reg(ffha_pkg::REG_BYTES, 48'd4096);
    send_idle_pct = 0;  recv_stall_pct = 0;  run_random(300);
    drain();
    write_reg(ffha_pkg::REG_BASE, rand_addr());
    write_reg(ffha_pkg::REG_BYTES, 48'hFFFF_FFFF);
    send_idle_pct = 48; recv_stall_pct = 0;  run_random(300);
    write_reg(ffha_pkg::REG_BASE, 48'd0);
    write_reg(ffha_pkg::REG_BYTES, 48'd2048);
    send_idle_pct = 0;  recv_stall_pct = 48; run_random(300);
    write_reg(ffha_pkg::REG_BYTES, 48'd1048576);
    send_idle_pct = 15; recv_stall_pct = 15; run_random(350);
  endtask

  initial begin
    rst = 1'b1; cfg_we = 1'b0; cfg_addr = 1'b0; cfg_data = '0;
    s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
    mismatches = 0; send_idle_pct = 0; recv_stall_pct = 0;
    base_reg = '0; span_reg = ffha_pkg::BYTES_RST;
    table_rebuild();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_tiny_heap();
    test_random();
    drain();
    if (mismatches == 0 && grant_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Watchdog
  initial begin
    #80_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/ffha_pkg.sv
sv/ffha_seg_ram.sv
sv/ffha_ctrl.sv
sv/first_fit_heap_allocator.sv
tb/tb_top.sv
